>>> rtl/mbrh_pkg.sv
package mbrh_pkg;

  // request op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // exception frame contents
  localparam logic [7:0] EXC_FLAG        = 8'h80;
  localparam logic [7:0] EXC_BAD_ADDRESS = 8'h02;
  localparam logic [7:0] EXC_BAD_COUNT   = 8'h03;
  localparam logic [5:0] EXC_FRAME_LEN   = 6'd5;

  // header bytes plus crc bytes around the data of a normal frame
  localparam logic [5:0] FRAME_OVERHEAD  = 6'd5;
  localparam logic [5:0] HDR_LEN         = 6'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef logic [15:0] crc_t;

  // one byte through the reflected modbus crc16
  function automatic crc_t crc_feed(input crc_t crc_in, input logic [7:0] data_byte);
    crc_t c;
    c = crc_in ^ {8'h00, data_byte};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/modbus_read_holding_responder_core.sv
// channel  | direction | handshake           | payload
// in_      | input     | in_valid / in_stall | op, slave id, func code, start, count, load
// out_     | output    | out_valid/out_stall | frame byte, last byte flag, exception flag
//
// a load item writes one entry of the register store when its index lies within the store
// a read request, once accepted, sends one frame byte per cycle unless out_stall holds it:
//   2*count+5 bytes for a normal frame (at most 63), 5 for an exception frame
// the frame walk reads the store one register ahead, so the single read port paces data
// rst_n is synchronous; it clears the store's valid bits, the sequencer and out_valid
// out_stall holds the output register; the sequencer waits, and in_stall stays high
// until the last byte of the frame has been loaded into the output register
module modbus_read_holding_responder_core #(
  parameter int NUM_REGS  = 64,
  parameter int MAX_COUNT = 29
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_slave_id,
  input  logic [7:0]  in_func_code,
  input  logic [15:0] in_start_addr,
  input  logic [15:0] in_reg_count,
  input  logic [5:0]  in_load_index,
  input  logic [15:0] in_load_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_byte,
  output logic        out_is_exception
);

  // loads only reach the first 64 entries; the rest of the store always reads zero
  localparam int STORE_DEPTH = (NUM_REGS < 64) ? NUM_REGS : 64;
  localparam int SIDX_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  // store
  logic [15:0]  mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_r;
  logic [15:0]  rdata_r;
  logic         rd_ok_r;
  logic         rd_en;
  logic [15:0]  rd_addr;
  logic [SIDX_W-1:0] rd_idx;
  logic         rd_in_range;
  logic         wr_en;
  logic [SIDX_W-1:0] wr_idx;

  // sequencer
  logic         state_r, state_nxt;
  logic [5:0]   pos_r;
  logic [5:0]   len_r;
  logic         exc_r;
  logic         hi_r;
  logic [7:0]   sid_r;
  logic [7:0]   fc_r;
  logic [7:0]   hdr2_r;
  logic [15:0]  cur_addr_r;
  mbrh_pkg::crc_t crc_r;

  logic         out_valid_r;
  logic [7:0]   out_byte_r;
  logic         out_last_r;
  logic         out_exc_r;

  logic         accept;
  logic         req_accept;
  logic         can_load;
  logic         advance;
  logic         bad_count;
  logic         bad_addr;
  logic [16:0]  end_sum;
  logic         in_data;
  logic         is_crc_lo;
  logic         is_crc_hi;
  logic         is_last;
  logic [15:0]  rword;
  logic [7:0]   next_byte;

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign req_accept = accept && (in_op == mbrh_pkg::OP_READ);
  assign can_load   = !out_valid_r || !out_stall;
  assign advance    = (state_r == ST_EMIT) && can_load;

  assign bad_count = (in_reg_count == 16'd0) || (in_reg_count > 16'(MAX_COUNT));
  assign end_sum   = {1'b0, in_start_addr} + {1'b0, in_reg_count};
  assign bad_addr  = end_sum > 17'(NUM_REGS);

  assign is_crc_hi = ({1'b0, pos_r} + 7'd1) == {1'b0, len_r};
  assign is_crc_lo = ({1'b0, pos_r} + 7'd2) == {1'b0, len_r};
  assign in_data   = (pos_r >= mbrh_pkg::HDR_LEN) && (({1'b0, pos_r} + 7'd2) < {1'b0, len_r});
  assign is_last   = is_crc_hi;

  assign rword = rd_ok_r ? rdata_r : 16'h0000;

  always_comb begin
    if (pos_r == 6'd0) begin
      next_byte = sid_r;
    end else if (pos_r == 6'd1) begin
      next_byte = fc_r;
    end else if (pos_r == 6'd2) begin
      next_byte = hdr2_r;
    end else if (in_data) begin
      next_byte = hi_r ? rword[15:8] : rword[7:0];
    end else if (is_crc_lo) begin
      next_byte = crc_r[7:0];
    end else begin
      next_byte = crc_r[15:8];
    end
  end

  // first register is fetched at accept, the next one as the low byte goes out
  assign rd_en   = req_accept || (advance && in_data && !hi_r);
  assign rd_addr = req_accept ? in_start_addr : cur_addr_r;
  assign rd_idx  = rd_addr[SIDX_W-1:0];
  assign rd_in_range = {1'b0, rd_addr} < 17'(STORE_DEPTH);

  assign wr_en  = accept && (in_op == mbrh_pkg::OP_LOAD) &&
                  ({1'b0, in_load_index} < 7'(STORE_DEPTH));
  assign wr_idx = in_load_index[SIDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= in_load_value;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_idx];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_accept) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (advance && is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      rd_ok_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= rd_in_range && valid_r[rd_idx];
      end
    end
  end

  // frame payload
  always_ff @(posedge clk) begin
    if (req_accept) begin
      sid_r      <= in_slave_id;
      pos_r      <= 6'd0;
      hi_r       <= 1'b1;
      crc_r      <= mbrh_pkg::CRC_INIT;
      cur_addr_r <= in_start_addr + 16'd1;
      if (bad_count) begin
        exc_r  <= 1'b1;
        fc_r   <= in_func_code | mbrh_pkg::EXC_FLAG;
        hdr2_r <= mbrh_pkg::EXC_BAD_COUNT;
        len_r  <= mbrh_pkg::EXC_FRAME_LEN;
      end else if (bad_addr) begin
        exc_r  <= 1'b1;
        fc_r   <= in_func_code | mbrh_pkg::EXC_FLAG;
        hdr2_r <= mbrh_pkg::EXC_BAD_ADDRESS;
        len_r  <= mbrh_pkg::EXC_FRAME_LEN;
      end else begin
        exc_r  <= 1'b0;
        fc_r   <= in_func_code;
        hdr2_r <= {2'b00, in_reg_count[4:0], 1'b0};
        len_r  <= {in_reg_count[4:0], 1'b0} + mbrh_pkg::FRAME_OVERHEAD;
      end
    end else if (advance) begin
      pos_r <= pos_r + 6'd1;
      if (in_data) begin
        hi_r <= !hi_r;
      end
      if (!is_crc_lo && !is_crc_hi) begin
        crc_r <= mbrh_pkg::crc_feed(crc_r, next_byte);
      end
      if (rd_en) begin
        cur_addr_r <= cur_addr_r + 16'd1;
      end
    end
    if (advance) begin
      out_byte_r <= next_byte;
      out_last_r <= is_last;
      out_exc_r  <= exc_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last_byte    = out_last_r;
  assign out_is_exception = out_exc_r;

  a_req_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    req_accept |=> (state_r == ST_EMIT) && (pos_r == 6'd0))
    else $error("request did not start a frame");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (pos_r < len_r))
    else $error("byte position ran past frame length");

  a_exc_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && exc_r |-> (len_r == mbrh_pkg::EXC_FRAME_LEN))
    else $error("exception frame with wrong length");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    advance && is_last |=> (state_r == ST_IDLE) && out_valid_r && out_last_r)
    else $error("last byte did not close the frame");

  a_no_read_during_load: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !rd_en && (state_r == ST_IDLE))
    else $error("store write overlapped a frame read");

endmodule

>>> verif/mbrh_frame_checker.sv
`timescale 1ns / 100ps

module mbrh_frame_checker #(
  parameter int NUM_REGS  = 64,
  parameter int MAX_COUNT = 29
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_slave_id,
  input  logic [7:0]  in_func_code,
  input  logic [15:0] in_start_addr,
  input  logic [15:0] in_reg_count,
  input  logic [5:0]  in_load_index,
  input  logic [15:0] in_load_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_last_byte,
  input  logic        out_is_exception,
  output int          fail_count,
  output int          pending,
  output int          bytes_checked,
  output int          exc_frames
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       exc;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];
  logic [15:0] shadow_regs[NUM_REGS];

  initial begin
    fail_count    = 0;
    pending       = 0;
    bytes_checked = 0;
    exc_frames    = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s, got 0x%0h expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // bit-serial form of the reflected crc16, one data bit per step
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ data[k];
      c  = c >> 1;
      if (fb) begin
        c = c ^ mbrh_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic expect_frame(input logic [7:0] sid, input logic [7:0] fc,
                              input logic [15:0] start, input logic [15:0] count);
    logic [7:0]  frame[$];
    logic [15:0] crc;
    logic        exc;
    int          last_addr;
    int          i;
    frame_byte_t fb;
    exc       = 1'b1;
    last_addr = int'(start) + int'(count) - 1;
    frame.push_back(sid);
    if (count == 16'd0 || int'(count) > MAX_COUNT) begin
      frame.push_back(fc | mbrh_pkg::EXC_FLAG);
      frame.push_back(mbrh_pkg::EXC_BAD_COUNT);
    end else if (last_addr >= NUM_REGS) begin
      // sum taken without wrap, so high start addresses fail here too
      frame.push_back(fc | mbrh_pkg::EXC_FLAG);
      frame.push_back(mbrh_pkg::EXC_BAD_ADDRESS);
    end else begin
      exc = 1'b0;
      frame.push_back(fc);
      frame.push_back(8'(2 * int'(count)));
      for (i = 0; i < int'(count); i++) begin
        frame.push_back(shadow_regs[int'(start) + i][15:8]);
        frame.push_back(shadow_regs[int'(start) + i][7:0]);
      end
    end
    crc = mbrh_pkg::CRC_INIT;
    for (i = 0; i < frame.size(); i++) begin
      crc = crc_step(crc, frame[i]);
    end
    frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
    for (i = 0; i < frame.size(); i++) begin
      fb.data = frame[i];
      fb.last = (i == frame.size() - 1);
      fb.exc  = exc;
      expected_bytes.push_back(fb);
    end
    if (exc) begin
      exc_frames++;
    end
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst_n) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        shadow_regs[r] = 16'h0000;
      end
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        bytes_checked++;
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected byte", out_byte, 0);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data) begin
            report_mismatch("frame byte", out_byte, want.data);
          end
          if (out_last_byte !== want.last) begin
            report_mismatch("last byte flag", out_last_byte, want.last);
          end
          if (out_is_exception !== want.exc) begin
            report_mismatch("exception flag", out_is_exception, want.exc);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_op == mbrh_pkg::OP_LOAD) begin
          if (int'(in_load_index) < NUM_REGS) begin
            shadow_regs[in_load_index] = in_load_value;
          end
        end else begin
          expect_frame(in_slave_id, in_func_code, in_start_addr, in_reg_count);
        end
      end
    end
    pending = expected_bytes.size();
  end

endmodule

>>> verif/tb_modbus_read_holding_responder_core.sv
`timescale 1ns / 100ps

module tb_modbus_read_holding_responder_core;

  localparam int NUM_REGS  = 64;
  localparam int MAX_COUNT = 29;
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam int RANDOM_ITEMS = 350;
  localparam int LONG_HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = mbrh_pkg::OP_LOAD;
  logic [7:0]  in_slave_id = 8'h00;
  logic [7:0]  in_func_code = 8'h00;
  logic [15:0] in_start_addr = 16'h0000;
  logic [15:0] in_reg_count = 16'h0000;
  logic [5:0]  in_load_index = 6'd0;
  logic [15:0] in_load_value = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_byte;
  logic        out_is_exception;

  logic hold_req = 1'b0;
  int   fails;
  int   pending_bytes;
  int   bytes_checked;
  int   exc_frames;
  int   loads_sent = 0;
  int   reads_sent = 0;

  modbus_read_holding_responder_core #(
    .NUM_REGS  (NUM_REGS),
    .MAX_COUNT (MAX_COUNT)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_slave_id      (in_slave_id),
    .in_func_code     (in_func_code),
    .in_start_addr    (in_start_addr),
    .in_reg_count     (in_reg_count),
    .in_load_index    (in_load_index),
    .in_load_value    (in_load_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_byte    (out_last_byte),
    .out_is_exception (out_is_exception)
  );

  mbrh_frame_checker #(
    .NUM_REGS  (NUM_REGS),
    .MAX_COUNT (MAX_COUNT)
  ) chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_slave_id      (in_slave_id),
    .in_func_code     (in_func_code),
    .in_start_addr    (in_start_addr),
    .in_reg_count     (in_reg_count),
    .in_load_index    (in_load_index),
    .in_load_value    (in_load_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_byte    (out_last_byte),
    .out_is_exception (out_is_exception),
    .fail_count       (fails),
    .pending          (pending_bytes),
    .bytes_checked    (bytes_checked),
    .exc_frames       (exc_frames)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // offer one item and wait until it is taken
  task automatic send_item(input logic op, input logic [7:0] sid, input logic [7:0] fc,
                           input logic [15:0] start, input logic [15:0] count,
                           input logic [5:0] lidx, input logic [15:0] lval);
    in_valid      <= 1'b1;
    in_op         <= op;
    in_slave_id   <= sid;
    in_func_code  <= fc;
    in_start_addr <= start;
    in_reg_count  <= count;
    in_load_index <= lidx;
    in_load_value <= lval;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (op == mbrh_pkg::OP_LOAD) begin
      loads_sent++;
    end else begin
      reads_sent++;
    end
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_frames();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic send_good_read();
    logic [15:0] count;
    count = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(1, 8))
                                        : 16'($urandom_range(1, MAX_COUNT));
    send_item(mbrh_pkg::OP_READ, 8'($urandom),
              ($urandom_range(0, 3) != 0) ? FC_READ_HOLDING : 8'($urandom),
              16'($urandom_range(0, NUM_REGS - int'(count))), count,
              6'($urandom), 16'($urandom));
  endtask

  task automatic send_random();
    int          pick;
    logic [15:0] start;
    logic [15:0] count;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_item(mbrh_pkg::OP_LOAD, 8'($urandom), 8'($urandom), 16'($urandom),
                16'($urandom), 6'($urandom), 16'($urandom));
    end else if (pick < 80) begin
      send_good_read();
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          start = 16'($urandom);
          count = 16'd0;
        end
        1: begin
          start = 16'($urandom_range(0, NUM_REGS - 1));
          count = 16'($urandom_range(MAX_COUNT + 1, 65535));
        end
        2: begin
          count = 16'($urandom_range(1, MAX_COUNT));
          start = 16'($urandom_range(NUM_REGS - int'(count) + 1, 65535));
        end
        default: begin
          start = 16'($urandom);
          count = 16'($urandom);
        end
      endcase
      send_item(mbrh_pkg::OP_READ, 8'($urandom), 8'($urandom), start, count,
                6'($urandom), 16'($urandom));
    end
  endtask

  // receiver: stall pattern of its own, plus a long hold on request
  initial begin
    int mode;
    int left;
    int hold;
    int tick;
    mode = 0;
    left = 0;
    hold = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        hold_req <= 1'b0;
        hold = LONG_HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= tick[2];
        endcase
      end
    end
  end

  initial begin
    int sent;
    int burst;
    int pause_at;
    bit pressed;
    sent     = 0;
    pressed  = 1'b0;
    pause_at = 100;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset contents read back as zero
    send_item(mbrh_pkg::OP_READ, 8'h00, FC_READ_HOLDING, 16'd0, 16'd1, 6'd0, 16'h0000);
    send_item(mbrh_pkg::OP_LOAD, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 6'd0, 16'hFFFF);
    send_item(mbrh_pkg::OP_LOAD, 8'h00, 8'h00, 16'h0000, 16'h0000, 6'd63, 16'h8001);
    send_item(mbrh_pkg::OP_LOAD, 8'h00, 8'h00, 16'h0000, 16'h0000, 6'd1, 16'h0000);
    send_item(mbrh_pkg::OP_LOAD, 8'h00, 8'h00, 16'h0000, 16'h0000, 6'd34, 16'h5AA5);
    send_item(mbrh_pkg::OP_LOAD, 8'h00, 8'h00, 16'h0000, 16'h0000, 6'd35, 16'hA55A);
    send_item(mbrh_pkg::OP_READ, 8'hFF, 8'hFF, 16'd0, 16'd29, 6'd63, 16'hFFFF);
    send_item(mbrh_pkg::OP_READ, 8'h11, FC_READ_HOLDING, 16'd35, 16'd29, 6'd0, 16'h0000);
    // last address one past the store
    send_item(mbrh_pkg::OP_READ, 8'h11, FC_READ_HOLDING, 16'd36, 16'd29, 6'd0, 16'h0000);
    send_item(mbrh_pkg::OP_READ, 8'h22, FC_READ_HOLDING, 16'd63, 16'd1, 6'd0, 16'h0000);
    send_item(mbrh_pkg::OP_READ, 8'h22, FC_READ_HOLDING, 16'd64, 16'd1, 6'd0, 16'h0000);
    send_item(mbrh_pkg::OP_READ, 8'h33, FC_READ_HOLDING, 16'hFFFF, 16'd1, 6'd0, 16'h0000);
    send_item(mbrh_pkg::OP_READ, 8'h33, FC_READ_HOLDING, 16'hFFFF, 16'd29, 6'd0, 16'h0000);
    // bad counts, including two that also have a bad address
    send_item(mbrh_pkg::OP_READ, 8'h44, FC_READ_HOLDING, 16'd0, 16'd0, 6'd0, 16'h0000);
    send_item(mbrh_pkg::OP_READ, 8'h44, FC_READ_HOLDING, 16'd0, 16'd30, 6'd0, 16'h0000);
    send_item(mbrh_pkg::OP_READ, 8'h44, FC_READ_HOLDING, 16'd0, 16'hFFFF, 6'd0, 16'h0000);
    send_item(mbrh_pkg::OP_READ, 8'h44, FC_READ_HOLDING, 16'hFFFF, 16'd0, 6'd0, 16'h0000);
    // function code with bit 7 already set, on both frame kinds
    send_item(mbrh_pkg::OP_READ, 8'h55, 8'h83, 16'd64, 16'd2, 6'd0, 16'h0000);
    send_item(mbrh_pkg::OP_READ, 8'h55, 8'h83, 16'd62, 16'd2, 6'd0, 16'h0000);
    send_item(mbrh_pkg::OP_READ, 8'hA5, 8'h00, 16'd33, 16'd3, 6'd63, 16'hFFFF);
    drain_frames();

    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++) begin
        send_random();
        sent++;
      end
      if (!pressed && sent >= RANDOM_ITEMS / 2) begin
        // output held off while the sender keeps offering reads
        pressed = 1'b1;
        hold_req <= 1'b1;
        for (int j = 0; j < 10; j++) begin
          send_good_read();
        end
        drain_frames();
      end
      if (sent >= pause_at) begin
        pause_at += 100;
        drain_frames();
      end
      idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
    end

    drain_frames();
    repeat (16) @(posedge clk);
    $display("covered %0d loads and %0d read requests, %0d answered with exception frames",
             loads_sent, reads_sent, exc_frames);
    $display("%0d response bytes compared, %0d mismatches", bytes_checked, fails);
    if (fails == 0) begin
      $display("modbus_read_holding_responder_core regression: pass");
    end else begin
      $display("modbus_read_holding_responder_core regression: fail");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout with %0d response bytes still expected", pending_bytes);
    $display("modbus_read_holding_responder_core regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
rtl/mbrh_pkg.sv
rtl/modbus_read_holding_responder_core.sv
verif/mbrh_frame_checker.sv
verif/tb_modbus_read_holding_responder_core.sv
